>>> src/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants for the strongest anchor selector
// Request and response beat layouts, request codes, store widths and the
// controller state type.
// ----------------------------------------------------------------------------
package sas_pkg;

   // store dimensions
   localparam int NUM_ANCHORS = 16;
   localparam int NUM_SLOTS   = NUM_ANCHORS + 1;             // anchors plus VIP slot
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int SUM_W       = 48;
   localparam int CNT_W       = 16;
   localparam int MEAN_W      = 32;
   localparam int STEP_W      = $clog2(SUM_W);
   localparam int ANCHOR_W    = 4;                           // reported index width

   // request codes
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_ADD    = 2'd1;
   localparam logic [1:0] REQ_SELECT = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [4:0]  anchor_slot;
      logic [31:0] rssi_sample;
      logic        listen_enable;
   } req_payload_type;

   typedef struct packed {
      logic                anchor_found;
      logic [ANCHOR_W-1:0] best_anchor;
      logic [MEAN_W-1:0]   best_mean;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

>>> src/strongest_anchor_selector.sv
// ----------------------------------------------------------------------------
// strongest_anchor_selector: per-anchor mean signal strength and best pick
// Accumulates saturating strength sums and sample counts per sender slot and,
// on request, finds the first anchor with the greatest positive mean using a
// single shared bit-serial divider.
// ----------------------------------------------------------------------------
//
//   channel | ports                      | direction | beat
//   --------+----------------------------+-----------+----------------------
//   request | req_valid/req_ready/req_data | in      | req_payload_type
//   result  | rsp_valid/rsp_ready/rsp_data | out     | rsp_payload_type
//
// Clear and add beats complete in the cycle they are taken.
// A select walks the anchors through one restoring divider (one quotient bit
// per cycle); empty anchors skip the divider. req_ready is low for that walk.
// Reset (synchronous, active high) zeroes all sums and counts at once.
// A finished result waits in the output register; further requests are taken
// meanwhile, and a later select holds its result until the register is free.
// ----------------------------------------------------------------------------
module strongest_anchor_selector (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sas_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sas_pkg::rsp_payload_type rsp_data
);

   // stores
   logic [sas_pkg::SUM_W-1:0] sum_ff [sas_pkg::NUM_SLOTS];
   logic [sas_pkg::CNT_W-1:0] cnt_ff [sas_pkg::NUM_SLOTS];

   // controller and divider registers
   sas_pkg::state_type         state_ff, state_in;
   logic [sas_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [sas_pkg::STEP_W-1:0] step_ff, step_in;
   logic [sas_pkg::SUM_W-1:0]  quo_ff, quo_in;
   logic [sas_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [sas_pkg::CNT_W-1:0]  dvsr_ff, dvsr_in;
   logic [sas_pkg::SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic [sas_pkg::MEAN_W-1:0] best_mean_ff, best_mean_in;
   logic                       found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   sas_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   // datapath nets
   logic                       req_fire;
   logic                       slot_ok;
   logic [sas_pkg::SLOT_W-1:0] rd_addr;
   logic [sas_pkg::SUM_W-1:0]  rd_sum;
   logic [sas_pkg::CNT_W-1:0]  rd_cnt;
   logic [sas_pkg::SUM_W:0]    sum_ext;
   logic [sas_pkg::SUM_W-1:0]  sum_wr;
   logic [sas_pkg::CNT_W-1:0]  cnt_wr;
   logic                       clr_all;
   logic                       add_en;
   logic [sas_pkg::CNT_W:0]    rem_sh;
   logic [sas_pkg::CNT_W:0]    rem_diff;
   logic [sas_pkg::MEAN_W-1:0] mean;

   assign req_fire = req_valid && req_ready;
   assign slot_ok  = ({1'b0, req_data.anchor_slot} <= 6'(sas_pkg::NUM_ANCHORS));

   // single read port: request slot while idle, walk index otherwise
   always_comb begin
      if (state_ff == sas_pkg::ST_IDLE) begin
         rd_addr = slot_ok ? sas_pkg::SLOT_W'(req_data.anchor_slot) : '0;
      end else begin
         rd_addr = idx_ff;
      end
   end
   assign rd_sum = sum_ff[rd_addr];
   assign rd_cnt = cnt_ff[rd_addr];

   // saturating accumulate
   assign sum_ext = {1'b0, rd_sum} + {{(sas_pkg::SUM_W + 1 - 32){1'b0}}, req_data.rssi_sample};
   assign sum_wr  = sum_ext[sas_pkg::SUM_W] ? '1 : sum_ext[sas_pkg::SUM_W-1:0];
   assign cnt_wr  = (&rd_cnt) ? rd_cnt : rd_cnt + 1'b1;

   assign clr_all = req_fire && (req_data.req_type == sas_pkg::REQ_CLEAR);
   assign add_en  = req_fire && (req_data.req_type == sas_pkg::REQ_ADD)
                    && req_data.listen_enable && slot_ok;

   // divider step: shift in next dividend bit, trial subtract
   assign rem_sh   = {rem_ff, quo_ff[sas_pkg::SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvsr_ff};

   // clamp quotient to the mean width
   assign mean = (|quo_ff[sas_pkg::SUM_W-1:sas_pkg::MEAN_W]) ? '1
                 : quo_ff[sas_pkg::MEAN_W-1:0];

   // store update
   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         for (int i = 0; i < sas_pkg::NUM_SLOTS; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else if (add_en) begin
         sum_ff[rd_addr] <= sum_wr;
         cnt_ff[rd_addr] <= cnt_wr;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sas_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dvsr_ff      <= dvsr_in;
      best_idx_ff  <= best_idx_in;
      best_mean_ff <= best_mean_in;
      found_ff     <= found_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvsr_in      = dvsr_ff;
      best_idx_in  = best_idx_ff;
      best_mean_in = best_mean_ff;
      found_in     = found_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      case (state_ff)
         sas_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_data.req_type == sas_pkg::REQ_SELECT)) begin
               idx_in       = '0;
               best_idx_in  = '0;
               best_mean_in = '0;
               found_in     = 1'b0;
               state_in     = sas_pkg::ST_LOAD;
            end
         end
         sas_pkg::ST_LOAD: begin
            quo_in  = rd_sum;
            rem_in  = '0;
            dvsr_in = rd_cnt;
            step_in = '0;
            if (rd_cnt == '0) begin
               // empty anchor: mean is zero
               quo_in   = '0;
               state_in = sas_pkg::ST_CMP;
            end else begin
               state_in = sas_pkg::ST_DIV;
            end
         end
         sas_pkg::ST_DIV: begin
            if (!rem_diff[sas_pkg::CNT_W]) begin
               rem_in = rem_diff[sas_pkg::CNT_W-1:0];
               quo_in = {quo_ff[sas_pkg::SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[sas_pkg::CNT_W-1:0];
               quo_in = {quo_ff[sas_pkg::SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == sas_pkg::STEP_W'(sas_pkg::SUM_W - 1)) begin
               state_in = sas_pkg::ST_CMP;
            end
         end
         sas_pkg::ST_CMP: begin
            // strict compare keeps the lowest index on ties
            if (mean > best_mean_ff) begin
               best_mean_in = mean;
               best_idx_in  = idx_ff;
               found_in     = 1'b1;
            end
            if (idx_ff == sas_pkg::SLOT_W'(sas_pkg::NUM_ANCHORS - 1)) begin
               state_in = sas_pkg::ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = sas_pkg::ST_LOAD;
            end
         end
         sas_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.anchor_found  = found_ff;
               rsp_data_in.best_anchor   = sas_pkg::ANCHOR_W'(best_idx_ff);
               rsp_data_in.best_mean     = best_mean_ff;
               state_in                  = sas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sas_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // no-hit result carries zeroes
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.anchor_found) |->
         (rsp_data.best_anchor == '0 && rsp_data.best_mean == '0))
      else $error("not-found result with nonzero fields");

   // a found anchor always has a positive mean
   a_found_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.anchor_found) |-> (rsp_data.best_mean != '0))
      else $error("found anchor with zero mean");

   // divider invariant: partial remainder below a nonzero divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sas_pkg::ST_DIV) |-> (dvsr_ff != '0 && rem_ff < dvsr_ff))
      else $error("divider remainder out of range");

   // walk never steps onto the VIP slot
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sas_pkg::ST_LOAD) |->
         (idx_ff < sas_pkg::SLOT_W'(sas_pkg::NUM_ANCHORS)))
      else $error("anchor walk index out of range");
`endif

endmodule

>>> sim/anchor_pick_checker.sv
// ----------------------------------------------------------------------------
// anchor_pick_checker: result checker for the strongest anchor selector
// Watches both channels. Every request beat taken by the block is applied to a
// private copy of the strength sums and sample counts, and each select adds the
// pick it should produce to a queue. Result beats are checked field by field
// against the head of that queue. Mismatches are counted and handed upward.
// ----------------------------------------------------------------------------
module anchor_pick_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  sas_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  sas_pkg::rsp_payload_type rsp_data,
   output int                       error_count,
   output int                       pending_results
);

   // shadow copy of the per-slot stores
   logic [sas_pkg::SUM_W-1:0] strength_total [sas_pkg::NUM_SLOTS];
   logic [sas_pkg::CNT_W-1:0] sample_tally   [sas_pkg::NUM_SLOTS];

   // picks owed by the block, oldest first
   sas_pkg::rsp_payload_type  owed_picks [$];
   int                        mismatches = 0;

   assign error_count = mismatches;

   function automatic void clear_stores();
      for (int i = 0; i < sas_pkg::NUM_SLOTS; i++) begin
         strength_total[i] = '0;
         sample_tally[i]   = '0;
      end
   endfunction

   // truncated mean, clamped to the reported width; empty slot gives zero
   function automatic logic [sas_pkg::MEAN_W-1:0] slot_average(int s);
      logic [sas_pkg::SUM_W-1:0] quotient;
      if (sample_tally[s] == '0) return '0;
      quotient = strength_total[s] / sas_pkg::SUM_W'(sample_tally[s]);
      if (quotient > sas_pkg::SUM_W'({sas_pkg::MEAN_W{1'b1}})) return '1;
      return quotient[sas_pkg::MEAN_W-1:0];
   endfunction

   // first anchor with the greatest positive mean; VIP slot left out
   function automatic sas_pkg::rsp_payload_type pick_strongest();
      sas_pkg::rsp_payload_type   pick;
      logic [sas_pkg::MEAN_W-1:0] avg;
      pick = '0;
      for (int i = 0; i < sas_pkg::NUM_ANCHORS; i++) begin
         avg = slot_average(i);
         if (avg > pick.best_mean) begin
            pick.best_mean    = avg;
            pick.best_anchor  = sas_pkg::ANCHOR_W'(i);
            pick.anchor_found = 1'b1;
         end
      end
      return pick;
   endfunction

   function automatic void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // one request beat taken by the block
   function automatic void apply_request(sas_pkg::req_payload_type beat);
      logic [sas_pkg::SUM_W:0] widened;
      int                      s;
      case (beat.req_type)
         sas_pkg::REQ_CLEAR: begin
            clear_stores();
         end
         sas_pkg::REQ_ADD: begin
            if (beat.listen_enable && beat.anchor_slot <= sas_pkg::NUM_ANCHORS) begin
               s = int'(beat.anchor_slot);
               widened = {1'b0, strength_total[s]} +
                         (sas_pkg::SUM_W+1)'(beat.rssi_sample);
               strength_total[s] = widened[sas_pkg::SUM_W] ? '1
                                   : widened[sas_pkg::SUM_W-1:0];
               if (sample_tally[s] != '1) sample_tally[s] = sample_tally[s] + 1'b1;
            end
         end
         sas_pkg::REQ_SELECT: begin
            owed_picks.push_back(pick_strongest());
         end
         default: begin
         end
      endcase
   endfunction

   // one result beat taken from the block
   function automatic void check_result(sas_pkg::rsp_payload_type got);
      sas_pkg::rsp_payload_type want;
      if (owed_picks.size() == 0) begin
         note_failure($sformatf("result beat with none owed: found=%b anchor=%0d mean=%h",
                                got.anchor_found, got.best_anchor, got.best_mean));
         return;
      end
      want = owed_picks.pop_front();
      if (got.anchor_found !== want.anchor_found || got.best_anchor !== want.best_anchor ||
          got.best_mean !== want.best_mean) begin
         note_failure($sformatf({"pick mismatch: expected found=%b anchor=%0d mean=%h, ",
                                 "got found=%b anchor=%0d mean=%h"},
                                want.anchor_found, want.best_anchor, want.best_mean,
                                got.anchor_found, got.best_anchor, got.best_mean));
      end
   endfunction

   // results first: a select taken this edge cannot answer at the same edge
   always @(posedge clock) begin
      if (reset) begin
         clear_stores();
         owed_picks.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) apply_request(req_data);
      end
      pending_results = owed_picks.size();
   end

endmodule

>>> sim/strongest_anchor_selector_tb.sv
// ----------------------------------------------------------------------------
// strongest_anchor_selector_tb: top-level testbench for the anchor selector
// Drives directed beats (empty stores, zero means, VIP slot, dropped and
// ignored measurements, ties, truncation), a run of full-scale measurements on
// one anchor, a back-pressure phase and random clear/measure/select sequences.
// The sender works in bursts and the receiver stalls on its own pattern; the
// attached checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module strongest_anchor_selector_tb;

   localparam logic [1:0] REQ_SPARE = 2'd3;     // unused request code
   localparam int ITEM_TARGET  = 1450;          // total request beats for the run
   localparam int SOAK_ADDS    = 200;           // full-scale beats on one anchor
   localparam int LONG_HOLD    = 3000;
   localparam int DRAIN_CYCLES = 900;           // longer than one full select walk

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   sas_pkg::req_payload_type req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   sas_pkg::rsp_payload_type rsp_data;

   logic hold_off_request = 1'b0;
   int   mismatch_total;
   int   awaited_results;
   int   burst_left   = 0;
   bit   gaps_on      = 1'b1;
   int   sent_items   = 0;

   strongest_anchor_selector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   anchor_pick_checker pick_watch (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .error_count     (mismatch_total),
      .pending_results (awaited_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic sas_pkg::req_payload_type make_req(logic [1:0] kind, logic [4:0] slot,
                                                         logic [31:0] power, logic listen);
      sas_pkg::req_payload_type beat;
      beat.req_type      = kind;
      beat.anchor_slot   = slot;
      beat.rssi_sample   = power;
      beat.listen_enable = listen;
      return beat;
   endfunction

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // present one beat, hold it until taken, then maybe close the burst
   task automatic offer(sas_pkg::req_payload_type beat);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(24, 1);
            pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1));
         end
      end
   endtask

   // sender idles until every owed pick has been returned
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (awaited_results == 0);
      @(posedge clock);
   endtask

   function automatic logic [4:0] pick_slot();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) return 5'($urandom_range(sas_pkg::NUM_ANCHORS - 1));
      if (roll < 90) return 5'(sas_pkg::NUM_ANCHORS);
      return 5'($urandom_range(31, sas_pkg::NUM_ANCHORS + 1));
   endfunction

   // small values make ties and truncation likely, large ones exercise width
   function automatic logic [31:0] pick_power();
      case ($urandom_range(3))
         0:       return 32'd0;
         1:       return 32'($urandom_range(15));
         2:       return $urandom;
         default: return {16'hFFFF, 16'($urandom)};
      endcase
   endfunction

   // mostly clear / measure / select runs, the rest noise
   task automatic random_sequence();
      int n_adds;
      if ($urandom_range(99) < 70) begin
         if ($urandom_range(1) == 1)
            offer(make_req(sas_pkg::REQ_CLEAR, 5'($urandom), $urandom, 1'($urandom)));
         n_adds = $urandom_range(30, 1);
         repeat (n_adds)
            offer(make_req(sas_pkg::REQ_ADD, pick_slot(), pick_power(),
                           $urandom_range(9) != 0));
         offer(make_req(sas_pkg::REQ_SELECT, 5'($urandom), $urandom, 1'($urandom)));
         if ($urandom_range(4) == 0)
            offer(make_req(sas_pkg::REQ_SELECT, 5'($urandom), $urandom, 1'($urandom)));
      end else begin
         repeat ($urandom_range(6, 1))
            offer(make_req(2'($urandom_range(3)), 5'($urandom), $urandom, 1'($urandom)));
      end
   endtask

   // receiver: segments of differing stall density, one long hold-off
   initial begin : result_sink
      int seg_left  = 0;
      int stall_pct = 0;
      int phase     = 0;
      bit held      = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(200, 20);
               phase    = 0;
               case ($urandom_range(4))
                  0:       stall_pct = 0;
                  1:       stall_pct = 30;
                  2:       stall_pct = 70;
                  3:       stall_pct = 95;
                  default: stall_pct = -1;     // periodic ready pattern from the phase count
               endcase
            end
            seg_left--;
            phase++;
            if (stall_pct < 0) rsp_ready <= (phase % 3 == 0);
            else               rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty stores, zero mean, VIP, dropped and ignored beats
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      offer(make_req(sas_pkg::REQ_ADD, 5'd0, 32'd0, 1'b1));
      offer(make_req(sas_pkg::REQ_ADD, 5'(sas_pkg::NUM_ANCHORS), 32'hFFFF_FFFF, 1'b1));
      offer(make_req(sas_pkg::REQ_ADD, 5'd15, 32'hFFFF_FFFF, 1'b0));
      offer(make_req(sas_pkg::REQ_ADD, 5'd17, 32'hFFFF_FFFF, 1'b1));
      offer(make_req(sas_pkg::REQ_ADD, 5'd31, 32'hFFFF_FFFF, 1'b1));
      offer(make_req(REQ_SPARE, 5'd2, 32'hFFFF_FFFF, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd31, 32'hFFFF_FFFF, 1'b1));

      // truncated means and a tie between anchors 2 and 9
      offer(make_req(sas_pkg::REQ_ADD, 5'd2, 32'd7, 1'b1));
      offer(make_req(sas_pkg::REQ_ADD, 5'd2, 32'd0, 1'b1));
      offer(make_req(sas_pkg::REQ_ADD, 5'd9, 32'd3, 1'b1));
      offer(make_req(sas_pkg::REQ_ADD, 5'd9, 32'd4, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));

      // top anchor index, full-scale mean, then a tie at full scale
      offer(make_req(sas_pkg::REQ_ADD, 5'd15, 32'hFFFF_FFFF, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      offer(make_req(sas_pkg::REQ_ADD, 5'd14, 32'hFFFF_FFFF, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      offer(make_req(sas_pkg::REQ_CLEAR, 5'd31, 32'hFFFF_FFFF, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));

      // back to back full-scale beats on one anchor, then a truncating zero
      gaps_on = 1'b0;
      repeat (SOAK_ADDS) offer(make_req(sas_pkg::REQ_ADD, 5'd3, 32'hFFFF_FFFF, 1'b1));
      offer(make_req(sas_pkg::REQ_ADD, 5'd1, 32'd5, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      offer(make_req(sas_pkg::REQ_ADD, 5'd3, 32'd0, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      gaps_on = 1'b1;
      offer(make_req(sas_pkg::REQ_CLEAR, 5'd0, 32'd0, 1'b0));
      drain_results();

      // back-pressure: results pile up while the receiver holds off
      hold_off_request <= 1'b1;
      offer(make_req(sas_pkg::REQ_ADD, 5'd4, 32'd100, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      offer(make_req(sas_pkg::REQ_ADD, 5'd5, 32'd200, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      offer(make_req(sas_pkg::REQ_ADD, 5'd6, 32'd300, 1'b1));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      offer(make_req(sas_pkg::REQ_SELECT, 5'd0, 32'd0, 1'b0));
      offer(make_req(sas_pkg::REQ_ADD, 5'd7, 32'd50, 1'b1));
      drain_results();

      // random sequences up to the beat budget
      while (sent_items < ITEM_TARGET) random_sequence();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results != 0)
         $display("ERROR: %0d selects never answered", awaited_results);
      if (mismatch_total == 0 && awaited_results == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> strongest_anchor_selector.f
src/sas_pkg.sv
src/strongest_anchor_selector.sv
sim/anchor_pick_checker.sv
sim/strongest_anchor_selector_tb.sv
